// ----- rtl/longest_palindrome_permutation_substring_defines.svh -----
`ifndef LONGEST_PALINDROME_PERMUTATION_SUBSTRING_DEFINES_SVH
`define LONGEST_PALINDROME_PERMUTATION_SUBSTRING_DEFINES_SVH

// check a property on every rising clock edge out of reset
`define LPPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition in one cycle implies another in the next cycle
`define LPPS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/lpps_pkg.sv -----
package lpps_pkg;

	localparam int OUT_W    = 17;
	localparam int LETTER_W = 5;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_WRPM,
		S_ISSUE,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic init;
		logic wr_pm;
		logic issue;
		logic own;
	} store_ctl_t;

	typedef struct packed {
		logic vld;
		logic hit;
	} store_res_t;

	typedef struct packed {
		logic clear;
		logic update;
	} unit_ctl_t;

endpackage

// ----- rtl/lpps_store.sv -----
module lpps_store #(
	parameter int A       = 26,
	parameter int MAX_LEN = 65536,
	parameter int LW      = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpps_pkg::store_ctl_t ctl,
	input  logic [A-1:0]        mask,
	input  logic [A-1:0]        query,
	input  logic [LW-1:0]       prefix,
	output lpps_pkg::store_res_t res,
	output logic [LW-1:0]       len
);

	bit   [LW-1:0] first_mem [2**A];
	logic [A-1:0]  pm_mem [MAX_LEN+1];

	logic          vld_s1, vld_s2;
	logic          own_s1, own_s2;
	logic [A-1:0]  q_s1, q_s2;
	logic [LW-1:0] len_s1, len_s2;
	logic [A-1:0]  pmd_s2;
	logic          hit;
	logic          ins;

	assign hit = vld_s2 && (len_s2 <= prefix) && (pmd_s2 == q_s2);
	assign ins = vld_s2 && own_s2 && !hit;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			first_mem[A'(0)] <= '0;
		end else if (ins) begin
			first_mem[q_s2] <= prefix;
		end
		if (ctl.issue) begin
			len_s1 <= first_mem[query];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			pm_mem[LW'(0)] <= '0;
		end else if (ctl.wr_pm) begin
			pm_mem[prefix] <= mask;
		end
		if (vld_s1) begin
			pmd_s2 <= pm_mem[len_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		own_s1 <= ctl.own;
		q_s1   <= query;
		own_s2 <= own_s1;
		q_s2   <= q_s1;
		len_s2 <= len_s1;
	end

	assign res.vld = vld_s2;
	assign res.hit = hit;
	assign len     = len_s2;

endmodule

// ----- rtl/lpps_unit.sv -----
module lpps_unit #(
	parameter int LW = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpps_pkg::unit_ctl_t ctl,
	input  logic [LW-1:0]       prefix,
	input  logic [LW-1:0]       len,
	output logic [LW-1:0]       best
);

	logic [LW-1:0] best_q;
	logic [LW-1:0] diff;

	assign diff = prefix - len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctl.clear) begin
			best_q <= '0;
		end else if (ctl.update && (diff > best_q)) begin
			best_q <= diff;
		end
	end

	assign best = best_q;

endmodule

// ----- rtl/longest_palindrome_permutation_substring.sv -----
// channel  dir  fields (tdata/tuser from bit 0 up)        accepted when
// s_*      in   tdata: letter[4:0], pad; tlast: last      s_tvalid && s_tready
// m_*      out  tdata: longest_length[16:0], pad          m_tvalid && m_tready
//
// Each letter gets one store lookup for its own mask and one per neighbor mask,
// issued one a cycle, then the read pipe drains.
// A letter past MAX_STRING_LENGTH skips the lookups and goes straight to the done state.
// Reset and each string end pass through an init state that seeds the mask-zero entry.
// The result waits in an output register; a new letter is taken meanwhile,
// and only a second string end stalls until the pending result is taken.
module longest_palindrome_permutation_substring #(
	parameter int ALPHABET_SIZE     = 26,
	parameter int MAX_STRING_LENGTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // letter[4:0], zero[7:5]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // longest_length[16:0], zero[23:17]
);

	localparam int A  = ALPHABET_SIZE;
	localparam int LW = $clog2(MAX_STRING_LENGTH + 1);
	localparam int KW = $clog2(A + 1);

	lpps_pkg::state_t state_q, state_d;

	logic [KW-1:0]              k_q;
	logic [A-1:0]               mask_q;
	logic [LW-1:0]              prefix_q;
	logic                       last_q;
	logic                       out_vld_q;
	logic [lpps_pkg::OUT_W-1:0] out_data_q;

	logic [lpps_pkg::LETTER_W-1:0] letter;
	logic                          accept;
	logic                          room;
	logic                          load;
	logic [A-1:0]                  query;
	logic [KW-1:0]                 km1;
	lpps_pkg::store_ctl_t          sctl;
	lpps_pkg::store_res_t          sres;
	lpps_pkg::unit_ctl_t           uctl;
	logic [LW-1:0]                 len;
	logic [LW-1:0]                 best;

	assign letter = s_tdata[lpps_pkg::LETTER_W-1:0];
	assign accept = s_tvalid && s_tready;
	assign room   = prefix_q < LW'(MAX_STRING_LENGTH);
	assign km1    = k_q - KW'(1);
	assign query  = (k_q == '0) ? mask_q : (mask_q ^ (A'(1) << km1));

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		load       = 1'b0;
		sctl       = '0;
		uctl       = '0;
		uctl.update = sres.vld && sres.hit;
		case (state_q)
			lpps_pkg::S_INIT: begin
				sctl.init = 1'b1;
				state_d   = lpps_pkg::S_IDLE;
			end
			lpps_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = room ? lpps_pkg::S_WRPM : lpps_pkg::S_DONE;
				end
			end
			lpps_pkg::S_WRPM: begin
				sctl.wr_pm = 1'b1;
				state_d    = lpps_pkg::S_ISSUE;
			end
			lpps_pkg::S_ISSUE: begin
				sctl.issue = 1'b1;
				sctl.own   = (k_q == '0);
				if (k_q == KW'(A)) begin
					state_d = lpps_pkg::S_DRAIN;
				end
			end
			lpps_pkg::S_DRAIN: begin
				if (!sres.vld || (k_q == '0)) begin
					state_d = lpps_pkg::S_DONE;
				end
			end
			lpps_pkg::S_DONE: begin
				if (!last_q) begin
					state_d = lpps_pkg::S_IDLE;
				end else if (!out_vld_q || m_tready) begin
					load       = 1'b1;
					uctl.clear = 1'b1;
					state_d    = lpps_pkg::S_INIT;
				end
			end
			default: begin
				state_d = lpps_pkg::S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpps_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			mask_q    <= '0;
			prefix_q  <= '0;
			last_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				last_q <= s_tlast;
				if (room) begin
					prefix_q <= prefix_q + LW'(1);
					if ({1'b0, letter} < (lpps_pkg::LETTER_W + 1)'(A)) begin
						mask_q <= mask_q ^ (A'(1) << letter);
					end
				end
			end
			if (state_q == lpps_pkg::S_ISSUE) begin
				k_q <= (k_q == KW'(A)) ? KW'(1) : k_q + KW'(1);
			end else if (state_q == lpps_pkg::S_DRAIN) begin
				k_q <= '0;
			end
			if (load) begin
				mask_q    <= '0;
				prefix_q  <= '0;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= lpps_pkg::OUT_W'(best);
		end
	end

	lpps_store #(
		.A       (A),
		.MAX_LEN (MAX_STRING_LENGTH),
		.LW      (LW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.mask   (mask_q),
		.query  (query),
		.prefix (prefix_q),
		.res    (sres),
		.len    (len)
	);

	lpps_unit #(
		.LW (LW)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (uctl),
		.prefix (prefix_q),
		.len    (len),
		.best   (best)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(24 - lpps_pkg::OUT_W){1'b0}}, out_data_q};

endmodule

// ----- rtl/lpps_checker.sv -----
`include "longest_palindrome_permutation_substring_defines.svh"

module lpps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	`LPPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")
	`LPPS_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "input beat taken without a busy cycle")
	`LPPS_ASSERT(a_new_result_busy, $rose(m_tvalid) |-> !s_tready, "result appeared while input side idle")
	`LPPS_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[23:17] == 7'd0), "result padding not zero")

endmodule

bind longest_palindrome_permutation_substring lpps_checker u_lpps_checker (.*);
